// ===== design/linear_volume_fade_ramp_unit_macros.svh =====
// Assertion macros used by the fade ramp controller.
`ifndef LINEAR_VOLUME_FADE_RAMP_UNIT_MACROS_SVH
`define LINEAR_VOLUME_FADE_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LVFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LVFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lvfr_pkg.sv =====
`timescale 1ns / 1ps

package lvfr_pkg;

    localparam int POS_W = 10;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_FADE_OUT = 2'd1;
    localparam logic [1:0] CMD_FADE_IN  = 2'd2;

    localparam logic [POS_W-1:0] POS_FULL = 10'd1000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] length_ms;
        logic [15:0] delta_ms;
    } t_in_item;

    typedef struct packed {
        logic             volume_write;
        logic [15:0]      volume_value;
        logic             stop_request;
        logic [POS_W-1:0] fade_position;
        logic             fading_in_now;
        logic             fading_out_now;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic mul_pos;
        logic mul_go;
        logic div_init;
        logic div_step;
        logic cap_vol;
        logic cap_pos;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

// ===== design/linear_volume_fade_ramp_unit.sv =====
`timescale 1ns / 1ps
// Linear volume fade generator. Every input transfer yields exactly one output transfer.
// Input channel: i_in_valid / o_in_ready with i_in_item (cmd, length_ms, delta_ms).
// Output channel: o_out_valid / i_out_ready with o_out_item (volume write, value,
// stop request, fade position in thousandths, and the two fade flags).
// The target volume is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it. Start commands and
// ticks that end or do not advance a fade go from the decide state straight to emit.
// A mid-fade tick runs multiply, divider init, QB divide steps and capture twice, where
// QB is the larger of VOLUME_BITS and 10; one shared multiplier and one shared
// restoring divider, one quotient bit per cycle, compute volume and then position.
// One item is processed at a time; the input is ready in the cycle after the result loads.
// Reset clears the fades, the elapsed time and the target volume; the position reads
// 1000 and no output is valid. When the receiver stalls, the finished result waits in
// the output register and one more item may be taken and processed; it then waits
// until that register drains.
module linear_volume_fade_ramp_unit #(
    parameter int VOLUME_BITS = 16,
    parameter int TIME_BITS   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [VOLUME_BITS-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lvfr_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lvfr_pkg::t_out_item    o_out_item
);
    import lvfr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lvfr_ctrl #(
        .VOLUME_BITS(VOLUME_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    lvfr_dp #(
        .VOLUME_BITS(VOLUME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (i_in_item),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_item     (o_out_item)
    );

endmodule

// ===== design/lvfr_dp.sv =====
`timescale 1ns / 1ps

module lvfr_dp #(
    parameter int VOLUME_BITS = 16,
    parameter int TIME_BITS   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [VOLUME_BITS-1:0] i_cfg_wdata,
    input  lvfr_pkg::t_in_item     i_item,
    input  lvfr_pkg::t_dp_cmd      i_cmd,
    output lvfr_pkg::t_dp_stat     o_stat,
    output lvfr_pkg::t_out_item    o_item
);
    import lvfr_pkg::*;

    localparam int QB = (VOLUME_BITS > POS_W) ? VOLUME_BITS : POS_W;
    localparam int PW = QB + TIME_BITS;

    logic [VOLUME_BITS-1:0] r_target;
    logic                   r_fade_in, n_fade_in;
    logic                   r_fade_out, n_fade_out;
    logic [TIME_BITS-1:0]   r_length, n_length;
    logic [TIME_BITS-1:0]   r_elapsed, n_elapsed;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_need_div, n_need_div;
    logic                   r_wr, n_wr;
    logic                   r_stop, n_stop;
    logic [VOLUME_BITS-1:0] r_vol, n_vol;
    logic [PW-1:0]          r_prod;
    logic [TIME_BITS-1:0]   r_rem;
    logic [QB-1:0]          r_qbits;
    t_out_item              r_out;

    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   sat;
    logic [QB-1:0]          mul_a;
    logic [TIME_BITS:0]     trial;
    logic [TIME_BITS:0]     diff;
    logic                   ge;

    assign sum   = {1'b0, r_elapsed} + (TIME_BITS + 1)'(i_item.delta_ms);
    assign sat   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    assign mul_a = i_cmd.mul_pos ? QB'(POS_FULL) : QB'(r_target);
    assign trial = {r_rem, r_qbits[QB-1]};
    assign diff  = trial - {1'b0, r_length};
    assign ge    = trial >= {1'b0, r_length};

    always_comb begin
        n_fade_in  = r_fade_in;
        n_fade_out = r_fade_out;
        n_length   = r_length;
        n_elapsed  = r_elapsed;
        n_pos      = r_pos;
        n_need_div = r_need_div;
        n_wr       = r_wr;
        n_stop     = r_stop;
        n_vol      = r_vol;
        if (i_cmd.accept) begin
            n_wr       = 1'b0;
            n_vol      = '0;
            n_stop     = 1'b0;
            n_need_div = 1'b0;
            case (i_item.cmd)
                CMD_FADE_OUT, CMD_FADE_IN: begin
                    n_fade_out = (i_item.cmd == CMD_FADE_OUT);
                    n_fade_in  = (i_item.cmd == CMD_FADE_IN);
                    n_length   = TIME_BITS'(i_item.length_ms);
                    n_elapsed  = '0;
                    n_wr       = (i_item.cmd == CMD_FADE_IN);
                    n_pos      = (TIME_BITS'(i_item.length_ms) == '0) ? POS_FULL : '0;
                end
                CMD_TICK: begin
                    if (r_fade_in || r_fade_out) begin
                        n_elapsed = sat;
                        if (sat >= r_length) begin
                            n_stop     = r_fade_out;
                            n_wr       = r_fade_in;
                            n_vol      = r_fade_in ? r_target : '0;
                            n_fade_in  = 1'b0;
                            n_fade_out = 1'b0;
                            n_pos      = POS_FULL;
                        end else begin
                            n_wr       = 1'b1;
                            n_need_div = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.cap_vol) begin
            n_vol = r_fade_out ? (r_target - VOLUME_BITS'(r_qbits)) : VOLUME_BITS'(r_qbits);
        end
        if (i_cmd.cap_pos) begin
            n_pos = POS_W'(r_qbits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_fade_in  <= 1'b0;
            r_fade_out <= 1'b0;
            r_length   <= '0;
            r_elapsed  <= '0;
            r_pos      <= POS_FULL;
            r_need_div <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            r_fade_in  <= n_fade_in;
            r_fade_out <= n_fade_out;
            r_length   <= n_length;
            r_elapsed  <= n_elapsed;
            r_pos      <= n_pos;
            r_need_div <= n_need_div;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr   <= n_wr;
        r_stop <= n_stop;
        r_vol  <= n_vol;
        if (i_cmd.mul_go) begin
            r_prod <= {TIME_BITS'(0), mul_a} * {QB'(0), r_elapsed};
        end
        if (i_cmd.div_init) begin
            r_rem   <= r_prod[PW-1:QB];
            r_qbits <= r_prod[QB-1:0];
        end else if (i_cmd.div_step) begin
            r_rem   <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            r_qbits <= {r_qbits[QB-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out.volume_write   <= r_wr;
            r_out.volume_value   <= 16'(r_vol);
            r_out.stop_request   <= r_stop;
            r_out.fade_position  <= r_pos;
            r_out.fading_in_now  <= r_fade_in;
            r_out.fading_out_now <= r_fade_out;
        end
    end

    assign o_stat.need_div = r_need_div;
    assign o_item          = r_out;

endmodule

// ===== design/lvfr_ctrl.sv =====
`timescale 1ns / 1ps
`include "linear_volume_fade_ramp_unit_macros.svh"

module lvfr_ctrl #(
    parameter int VOLUME_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  lvfr_pkg::t_dp_stat i_stat,
    output lvfr_pkg::t_dp_cmd  o_cmd
);
    import lvfr_pkg::*;

    localparam int QB    = (VOLUME_BITS > POS_W) ? VOLUME_BITS : POS_W;
    localparam int CNT_W = $clog2(QB + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DINIT  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_CAP    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pass, n_pass;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_pass  = 1'b0;
                n_state = i_stat.need_div ? S_MUL : S_EMIT;
            end
            S_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_pos = r_pass;
                n_state       = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QB - 1)) begin
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                if (!r_pass) begin
                    o_cmd.cap_vol = 1'b1;
                    n_pass        = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    o_cmd.cap_pos = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `LVFR_ASSERT_NOW(a_no_overwrite, o_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before transfer")
    `LVFR_ASSERT_NEXT(a_accept_decide, i_in_valid && o_in_ready, r_state == S_DECIDE, "accept did not start work")
    `LVFR_ASSERT_NOW(a_cnt_range, r_state == S_DIV, r_cnt < CNT_W'(QB), "divider count overrun")

endmodule

// ===== bench/linear_volume_fade_ramp_unit_test.sv =====
`timescale 1ns / 1ps

module linear_volume_fade_ramp_unit_test;
    import lvfr_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         IDLE_PCT    = 26;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    linear_volume_fade_ramp_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Predicted fade state.
    logic        ramp_out;
    logic        ramp_in;
    logic [23:0] ramp_len;
    logic [23:0] ramp_time;
    logic [15:0] full_vol;

    t_out_item awaited_fade_results[$];

    int  mismatches      = 0;
    int  commands_sent   = 0;
    int  results_seen    = 0;
    int  volume_writes   = 0;
    int  stop_requests   = 0;
    int  volume_settings = 0;
    int  hold_request    = 0;
    bit  steady          = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [POS_W-1:0] fade_position_now();
        logic [63:0] p;
        if (ramp_len == '0) begin
            return POS_FULL;
        end
        p = (64'(ramp_time) * 64'd1000) / 64'(ramp_len);
        return (p > 64'd1000) ? POS_FULL : POS_W'(p);
    endfunction

    function automatic t_out_item next_fade_result(t_in_item it);
        t_out_item   r;
        logic [24:0] sum;
        logic [63:0] part;
        r = '0;
        if (it.cmd == CMD_FADE_OUT || it.cmd == CMD_FADE_IN) begin
            ramp_out  = (it.cmd == CMD_FADE_OUT);
            ramp_in   = (it.cmd == CMD_FADE_IN);
            ramp_len  = it.length_ms;
            ramp_time = '0;
            if (it.cmd == CMD_FADE_IN) begin
                r.volume_write = 1'b1;
            end
        end else if (it.cmd == CMD_TICK && (ramp_out || ramp_in)) begin
            sum       = {1'b0, ramp_time} + 25'(it.delta_ms);
            ramp_time = sum[24] ? 24'hFF_FFFF : sum[23:0];
            if (ramp_time >= ramp_len) begin
                if (ramp_out) begin
                    r.stop_request = 1'b1;
                    ramp_out = 1'b0;
                end
                if (ramp_in) begin
                    r.volume_write = 1'b1;
                    r.volume_value = full_vol;
                    ramp_in = 1'b0;
                end
            end else begin
                part = (64'(full_vol) * 64'(ramp_time)) / 64'(ramp_len);
                r.volume_write = 1'b1;
                r.volume_value = ramp_out ? full_vol - part[15:0] : part[15:0];
            end
        end
        r.fade_position  = fade_position_now();
        r.fading_in_now  = ramp_in;
        r.fading_out_now = ramp_out;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: random stalls, long holds on request, and result checking.
    initial begin
        int        hold_left;
        t_out_item want;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                results_seen++;
                if (awaited_fade_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, o_out_item);
                    mismatches++;
                end else begin
                    want = awaited_fade_results.pop_front();
                    check_field("volume_write", 32'(want.volume_write),
                                32'(o_out_item.volume_write));
                    check_field("volume_value", 32'(want.volume_value),
                                32'(o_out_item.volume_value));
                    check_field("stop_request", 32'(want.stop_request),
                                32'(o_out_item.stop_request));
                    check_field("fade_position", 32'(want.fade_position),
                                32'(o_out_item.fade_position));
                    check_field("fading_in_now", 32'(want.fading_in_now),
                                32'(o_out_item.fading_in_now));
                    check_field("fading_out_now", 32'(want.fading_out_now),
                                32'(o_out_item.fading_out_now));
                    if (want.volume_write) volume_writes++;
                    if (want.stop_request) stop_requests++;
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timed out after %0d cycles with no transfer.", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Valid is left high after a transfer so that back-to-back items never toggle it.
    task automatic offer_command(logic [1:0] cmd, logic [23:0] dur, logic [15:0] delta);
        t_in_item it;
        int       gap;
        it.cmd       = cmd;
        it.length_ms = dur;
        it.delta_ms  = delta;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        awaited_fade_results.push_back(next_fade_result(it));
        commands_sent++;
    endtask

    task automatic set_volume(logic [15:0] v);
        i_in_valid <= 1'b0;
        while (awaited_fade_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        full_vol = v;
        volume_settings++;
    endtask

    task automatic test_directed_cases();
        set_volume(16'hFFFF);
        offer_command(CMD_UNUSED, 24'd0, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'hFFFF);
        offer_command(CMD_FADE_IN, 24'd0, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd0);
        offer_command(CMD_FADE_OUT, 24'd1000, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd1);
        offer_command(CMD_TICK, 24'd0, 16'd499);
        offer_command(CMD_UNUSED, 24'hFF_FFFF, 16'hFFFF);
        offer_command(CMD_TICK, 24'd0, 16'hFFFF);
        offer_command(CMD_TICK, 24'd0, 16'd5);
        offer_command(CMD_FADE_OUT, 24'd0, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd0);
        offer_command(CMD_FADE_IN, 24'hFF_FFFF, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'hFFFF);
        offer_command(CMD_FADE_OUT, 24'd3, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd1);
        offer_command(CMD_FADE_IN, 24'd5, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd2);
        offer_command(CMD_TICK, 24'd0, 16'd3);
        offer_command(CMD_FADE_IN, 24'd1, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd0);
        offer_command(CMD_TICK, 24'd0, 16'd1);
    endtask

    // The longest fade needs 257 maximal ticks, the last of which saturates the time.
    task automatic test_elapsed_saturation();
        set_volume(16'($urandom()));
        offer_command(CMD_FADE_IN, 24'hFF_FFFF, 16'($urandom()));
        repeat (257) offer_command(CMD_TICK, 24'($urandom()), 16'hFFFF);
        offer_command(CMD_TICK, 24'd0, 16'hFFFF);
    endtask

    task automatic test_output_backpressure();
        set_volume(16'h8000);
        steady       = 1;
        hold_request = 400;
        offer_command(CMD_FADE_OUT, 24'd800, 16'd0);
        repeat (11) offer_command(CMD_TICK, 24'd0, 16'd60);
        steady = 0;
    endtask

    task automatic offer_fade_sequence();
        logic [23:0] dur;
        int          sel;
        int          ticks;
        sel = $urandom_range(9);
        if (sel == 0) begin
            dur = '0;
        end else if (sel == 1) begin
            dur = 24'($urandom());
        end else begin
            dur = 24'($urandom_range(1, 3000));
        end
        offer_command($urandom_range(1) ? CMD_FADE_IN : CMD_FADE_OUT, dur,
                      16'($urandom()));
        ticks = $urandom_range(1, 10);
        repeat (ticks) begin
            if ($urandom_range(9) == 0) begin
                offer_command(CMD_UNUSED, 24'($urandom()), 16'($urandom()));
            end else if ($urandom_range(7) == 0) begin
                offer_command(CMD_TICK, 24'($urandom()), 16'($urandom()));
            end else begin
                offer_command(CMD_TICK, 24'($urandom()),
                              16'($urandom_range(0, (dur > 24'd60000) ? 20000 : dur / 3 + 1)));
            end
        end
    endtask

    task automatic test_random_fades();
        logic [15:0] phase_vol[5];
        int          phase_start;
        phase_vol[0] = 16'd0;
        phase_vol[1] = 16'hFFFF;
        phase_vol[2] = 16'($urandom());
        phase_vol[3] = 16'd1;
        phase_vol[4] = 16'($urandom());
        for (int ph = 0; ph < 5; ph++) begin
            set_volume(phase_vol[ph]);
            steady      = (ph == 2);
            phase_start = commands_sent;
            while (commands_sent - phase_start < 210) begin
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(1, 4)) begin
                        offer_command(2'($urandom()), 24'($urandom()), 16'($urandom()));
                    end
                end else begin
                    offer_fade_sequence();
                end
            end
        end
        steady = 0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        ramp_out    = 1'b0;
        ramp_in     = 1'b0;
        ramp_len    = '0;
        ramp_time   = '0;
        full_vol    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_elapsed_saturation();
        test_output_backpressure();
        test_random_fades();

        i_in_valid <= 1'b0;
        while (awaited_fade_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d commands and checked %0d results (%0d volume writes, %0d stops).",
                 commands_sent, results_seen, volume_writes, stop_requests);
        $display("Used %0d target volume settings, a saturated fade and a long output hold.",
                 volume_settings);
        if (mismatches == 0 && awaited_fade_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lvfr_pkg.sv
design/lvfr_dp.sv
design/lvfr_ctrl.sv
design/linear_volume_fade_ramp_unit.sv
bench/linear_volume_fade_ramp_unit_test.sv
